// ===== design/morph_boundary_extract_3x3_top_macros.svh =====
// Assertion macros shared by the boundary extraction RTL.
`ifndef MORPH_BOUNDARY_EXTRACT_3X3_TOP_MACROS_SVH
`define MORPH_BOUNDARY_EXTRACT_3X3_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define MBE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define MBE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/mbe_pkg.sv =====
// Types and constants of the 3x3 morphological boundary extraction block.
`default_nettype none

package mbe_pkg;

  localparam int PIX_W      = 8;
  localparam int FW_W       = 9;
  localparam int FH_W       = 13;
  localparam int MASK_W     = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int ROW_W      = 13;
  localparam int OROW_W     = 12;
  localparam int WIN_N      = 9;

  localparam logic [PIX_W-1:0]  PIX_MAX    = 8'hFF;
  localparam logic [FW_W-1:0]   FW_RST     = 9'd256;
  localparam logic [FH_W-1:0]   FH_RST     = 13'd256;
  localparam logic [MASK_W-1:0] MASK_RST   = 9'd84;
  localparam logic [FH_W-1:0]   MAX_HEIGHT = 13'd4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_ELEMENT_MASK = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic             emit;
    logic             last;
    logic             in_frame;
    logic             col_zero;
    logic             row_ge1;
    logic             row_ge2;
    logic [PIX_W-1:0] pix;
  } item_t;

endpackage

`default_nettype wire

// ===== design/mbe_if.sv =====
// Stream interfaces for the pixel request and result channels.
`default_nettype none

interface mbe_in_if;
  logic                    valid;
  logic                    ready;
  logic                    func;
  logic [mbe_pkg::PIX_W-1:0] pixel_in;

  modport source (output valid, output func, output pixel_in, input ready);
  modport sink   (input valid, input func, input pixel_in, output ready);
endinterface

interface mbe_out_if;
  logic                    valid;
  logic                    ready;
  logic [mbe_pkg::PIX_W-1:0] boundary_pixel;
  logic                    frame_last;

  modport source (output valid, output boundary_pixel, output frame_last, input ready);
  modport sink   (input valid, input boundary_pixel, input frame_last, output ready);
endinterface

`default_nettype wire

// ===== design/mbe_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none

module mbe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/mbe_ctrl.sv =====
// Configuration registers, frame position counters and request decode.
`default_nettype none
`include "morph_boundary_extract_3x3_top_macros.svh"

module mbe_ctrl #(
  parameter int MAX_WIDTH = 256
) (
  input  logic                             clk,
  input  logic                             rst_n,
  mbe_in_if.sink                           in_chan,
  input  logic                             s1_free,
  input  logic                             cfg_we,
  input  logic [mbe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mbe_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output logic                             item_valid,
  output mbe_pkg::item_t                   item,
  output logic [$clog2(MAX_WIDTH)-1:0]     item_addr,
  output logic [mbe_pkg::MASK_W-1:0]       element_mask,
  output logic                             geom_restart
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam logic [COL_W-1:0] LAST_MAX = COL_W'(MAX_WIDTH - 1);

  logic [mbe_pkg::FW_W-1:0]   frame_width_r;
  logic [mbe_pkg::FH_W-1:0]   frame_height_r;
  logic [mbe_pkg::MASK_W-1:0] element_mask_r;

  logic [mbe_pkg::ROW_W-1:0]  in_row_r, in_row_nxt;
  logic [COL_W-1:0]           in_col_r, in_col_nxt;
  logic [mbe_pkg::OROW_W-1:0] out_row_r, out_row_nxt;
  logic [COL_W-1:0]           out_col_r, out_col_nxt;

  logic [COL_W-1:0]           last_col;
  logic [mbe_pkg::OROW_W-1:0] last_row;
  logic                       fire;
  logic                       in_frame;
  logic                       emit;
  logic                       is_last;
  logic                       pos_zero;
  mbe_pkg::cfg_reg_t          cfg_sel;

  assign cfg_sel       = mbe_pkg::cfg_reg_t'(cfg_index);
  assign in_chan.ready = s1_free;
  assign element_mask  = element_mask_r;
  assign item_addr     = in_col_r;
  assign pos_zero      = (in_row_r == '0) && (in_col_r == '0) &&
                         (out_row_r == '0) && (out_col_r == '0);

  always_comb begin
    geom_restart = 1'b0;
    unique case (cfg_sel) inside
      mbe_pkg::CFG_FRAME_WIDTH, mbe_pkg::CFG_FRAME_HEIGHT: geom_restart = cfg_we;
      default: geom_restart = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= mbe_pkg::FW_RST;
      frame_height_r <= mbe_pkg::FH_RST;
      element_mask_r <= mbe_pkg::MASK_RST;
    end else if (cfg_we) begin
      unique case (cfg_sel)
        mbe_pkg::CFG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata[mbe_pkg::FW_W-1:0];
        mbe_pkg::CFG_FRAME_HEIGHT: frame_height_r <= cfg_wdata[mbe_pkg::FH_W-1:0];
        mbe_pkg::CFG_ELEMENT_MASK: element_mask_r <= cfg_wdata[mbe_pkg::MASK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (frame_width_r == '0) begin
      last_col = '0;
    end else if (32'(frame_width_r) > 32'(MAX_WIDTH)) begin
      last_col = LAST_MAX;
    end else begin
      last_col = COL_W'(frame_width_r - 9'd1);
    end

    if (frame_height_r == '0) begin
      last_row = '0;
    end else if (frame_height_r > mbe_pkg::MAX_HEIGHT) begin
      last_row = '1;
    end else begin
      last_row = mbe_pkg::OROW_W'(frame_height_r - 13'd1);
    end

    fire     = in_chan.valid && s1_free;
    in_frame = in_row_r <= {1'b0, last_row};
    emit     = (in_row_r >= 13'd2) || ((in_row_r != '0) && (in_col_r != '0));
    is_last  = emit && (out_row_r == last_row) && (out_col_r == last_col);

    item_valid    = fire && !(in_frame && in_chan.func);
    item.emit     = emit;
    item.last     = is_last;
    item.in_frame = in_frame;
    item.col_zero = in_col_r == '0;
    item.row_ge1  = in_row_r != '0;
    item.row_ge2  = in_row_r >= 13'd2;
    item.pix      = in_frame ? in_chan.pixel_in : mbe_pkg::PIX_MAX;

    in_row_nxt  = in_row_r;
    in_col_nxt  = in_col_r;
    out_row_nxt = out_row_r;
    out_col_nxt = out_col_r;
    if (item_valid) begin
      if (in_col_r == last_col) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + 1'b1;
      end else begin
        in_col_nxt = in_col_r + 1'b1;
      end
      if (emit) begin
        if (out_col_r == last_col) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + 1'b1;
        end else begin
          out_col_nxt = out_col_r + 1'b1;
        end
      end
      if (is_last) begin
        in_row_nxt  = '0;
        in_col_nxt  = '0;
        out_row_nxt = '0;
        out_col_nxt = '0;
      end
    end
    if (geom_restart) begin
      in_row_nxt  = '0;
      in_col_nxt  = '0;
      out_row_nxt = '0;
      out_col_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_row_r  <= '0;
      in_col_r  <= '0;
      out_row_r <= '0;
      out_col_r <= '0;
    end else begin
      in_row_r  <= in_row_nxt;
      in_col_r  <= in_col_nxt;
      out_row_r <= out_row_nxt;
      out_col_r <= out_col_nxt;
    end
  end

  `MBE_ASSERT_NXT(a_last_restart, item_valid && item.last, pos_zero, "positions not restarted")
  `MBE_ASSERT_IMP(a_out_behind, 1'b1, mbe_pkg::ROW_W'(out_row_r) <= in_row_r, "output row ahead")

endmodule

`default_nettype wire

// ===== design/mbe_win.sv =====
// Line buffer RAMs, 3x3 window, erosion datapath and result register.
`default_nettype none
`include "morph_boundary_extract_3x3_top_macros.svh"

module mbe_win #(
  parameter int MAX_WIDTH = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         item_valid,
  input  mbe_pkg::item_t               item,
  input  logic [$clog2(MAX_WIDTH)-1:0] item_addr,
  input  logic [mbe_pkg::MASK_W-1:0]   element_mask,
  input  logic                         geom_restart,
  output logic                         s1_free,
  mbe_out_if.source                    out_chan
);

  localparam int COL_W = $clog2(MAX_WIDTH);

  logic                       s1_valid_r;
  mbe_pkg::item_t             s1_r;
  logic [COL_W-1:0]           s1_addr_r;
  logic                       s1_fwd_r;
  logic [mbe_pkg::PIX_W-1:0]  s1_fwd_up_r, s1_fwd_lo_r;
  logic                       s1_adv;
  logic                       s1_stall;
  logic                       fwd_nxt;

  logic [mbe_pkg::PIX_W-1:0]  ram_up_q, ram_lo_q;
  logic [mbe_pkg::PIX_W-1:0]  mem_up, mem_lo;
  logic [mbe_pkg::PIX_W-1:0]  up, lo;
  logic                       ram_we;

  logic [mbe_pkg::PIX_W-1:0]  win_r   [mbe_pkg::WIN_N];
  logic [mbe_pkg::PIX_W-1:0]  win_nxt [mbe_pkg::WIN_N];
  logic [mbe_pkg::PIX_W-1:0]  e       [mbe_pkg::WIN_N];
  logic [mbe_pkg::PIX_W-1:0]  ero;
  logic [mbe_pkg::PIX_W-1:0]  res;

  logic                       out_valid_r;
  logic [mbe_pkg::PIX_W-1:0]  out_pix_r;
  logic                       out_last_r;

  assign s1_adv   = s1_valid_r && (!s1_r.emit || !out_valid_r || out_chan.ready);
  assign s1_stall = s1_valid_r && !s1_adv;
  assign s1_free  = !s1_valid_r || s1_adv;
  assign ram_we   = s1_adv && s1_r.in_frame;
  assign fwd_nxt  = item_valid && s1_valid_r && s1_r.in_frame && (s1_addr_r == item_addr);

  mbe_ram #(.WIDTH(mbe_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_ram_upper (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_addr_r),
    .wdata (mem_lo),
    .re    (item_valid),
    .raddr (item_addr),
    .rdata (ram_up_q)
  );

  mbe_ram #(.WIDTH(mbe_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_ram_lower (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_addr_r),
    .wdata (s1_r.pix),
    .re    (item_valid),
    .raddr (item_addr),
    .rdata (ram_lo_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_free) begin
      s1_valid_r <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && item_valid) begin
      s1_r        <= item;
      s1_addr_r   <= item_addr;
      s1_fwd_r    <= fwd_nxt;
      s1_fwd_up_r <= mem_lo;
      s1_fwd_lo_r <= s1_r.pix;
    end
  end

  always_comb begin
    mem_up = s1_fwd_r ? s1_fwd_up_r : ram_up_q;
    mem_lo = s1_fwd_r ? s1_fwd_lo_r : ram_lo_q;
    up     = s1_r.row_ge2 ? mem_up : mbe_pkg::PIX_MAX;
    lo     = s1_r.row_ge1 ? mem_lo : mbe_pkg::PIX_MAX;

    for (int r = 0; r < 3; r++) begin
      if (s1_r.col_zero) begin
        e[r*3+0]       = win_r[r*3+1];
        e[r*3+1]       = win_r[r*3+2];
        e[r*3+2]       = mbe_pkg::PIX_MAX;
        win_nxt[r*3+0] = mbe_pkg::PIX_MAX;
        win_nxt[r*3+1] = mbe_pkg::PIX_MAX;
      end else begin
        win_nxt[r*3+0] = win_r[r*3+1];
        win_nxt[r*3+1] = win_r[r*3+2];
        e[r*3+0]       = win_r[r*3+1];
        e[r*3+1]       = win_r[r*3+2];
        e[r*3+2]       = mbe_pkg::PIX_MAX;
      end
    end
    win_nxt[2] = up;
    win_nxt[5] = lo;
    win_nxt[8] = s1_r.pix;
    if (!s1_r.col_zero) begin
      e[2] = up;
      e[5] = lo;
      e[8] = s1_r.pix;
    end

    ero = mbe_pkg::PIX_MAX;
    for (int k = 0; k < mbe_pkg::WIN_N; k++) begin
      if (element_mask[k]) begin
        ero = ero & e[mbe_pkg::WIN_N-1-k];
      end
    end
    res = e[4] - ero;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || geom_restart) begin
      for (int k = 0; k < mbe_pkg::WIN_N; k++) begin
        win_r[k] <= mbe_pkg::PIX_MAX;
      end
    end else if (s1_adv) begin
      for (int k = 0; k < mbe_pkg::WIN_N; k++) begin
        win_r[k] <= s1_r.last ? mbe_pkg::PIX_MAX : win_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_r.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_r.emit) begin
      out_pix_r  <= res;
      out_last_r <= s1_r.last;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.boundary_pixel = out_pix_r;
  assign out_chan.frame_last     = out_last_r;

  `MBE_ASSERT_NXT(a_s1_hold, s1_stall, s1_valid_r && $stable(s1_addr_r), "request lost")
  `MBE_ASSERT_NXT(a_out_load, s1_adv && s1_r.emit, out_valid_r, "result not loaded")

endmodule

`default_nettype wire

// ===== design/morph_boundary_extract_3x3_top.sv =====
// Top level of the 3x3 morphological boundary extraction block.
//
//   channel   kind        handshake           payload
//   in_chan   request in  valid/ready         func, pixel_in
//   out_chan  result out  valid/ready         boundary_pixel, frame_last
//   cfg_*     config in   cfg_we, no wait     cfg_index, cfg_wdata
//
// One request per cycle while the output is not stalled; a request is registered
// in the window stage and its result in the output register, and results trail
// their pixels by width+1 requests. Line buffer RAM read at accept and write-back
// from the window stage set the rate; same-column overlap (width 1) is forwarded.
// Reset is synchronous; the line buffers are not cleared.
// With out_chan.ready low, one more result-producing request enters the window
// stage, then ready drops.
`default_nettype none

module morph_boundary_extract_3x3_top #(
  parameter int MAX_WIDTH = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  mbe_in_if.sink                         in_chan,
  mbe_out_if.source                      out_chan,
  input  logic                           cfg_we,
  input  logic [mbe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbe_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int COL_W = $clog2(MAX_WIDTH);

  logic                       s1_free;
  logic                       item_valid;
  mbe_pkg::item_t             item;
  logic [COL_W-1:0]           item_addr;
  logic [mbe_pkg::MASK_W-1:0] element_mask;
  logic                       geom_restart;

  mbe_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_chan      (in_chan),
    .s1_free      (s1_free),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .item_valid   (item_valid),
    .item         (item),
    .item_addr    (item_addr),
    .element_mask (element_mask),
    .geom_restart (geom_restart)
  );

  mbe_win #(.MAX_WIDTH(MAX_WIDTH)) u_win (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item         (item),
    .item_addr    (item_addr),
    .element_mask (element_mask),
    .geom_restart (geom_restart),
    .s1_free      (s1_free),
    .out_chan     (out_chan)
  );

endmodule

`default_nettype wire

// ===== tb/morph_boundary_extract_3x3_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the 3x3 boundary extraction block: directed and random frames against a predictor.
module morph_boundary_extract_3x3_top_tb;
  import mbe_pkg::*;

  localparam int MAX_W         = 256;
  localparam int MAX_H         = 4096;
  localparam logic FUNC_PIXEL  = 1'b0;
  localparam logic FUNC_FLUSH  = 1'b1;
  localparam int SETTLE_CYCLES = 10;
  localparam int DRAIN_CYCLES  = 20;
  localparam int QUIET_LIMIT   = 2000;
  localparam int RANDOM_ITEMS  = 300;
  localparam int WIDE_EXTRA    = 24;
  localparam int TALL_ITEMS    = 24;

  typedef enum int {TEXTURE_NOISE, TEXTURE_BINARY, TEXTURE_BRIGHT} texture_t;

  typedef struct packed {
    logic [PIX_W-1:0] boundary_pixel;
    logic             frame_last;
  } boundary_t;

  class boundary_predictor;
    logic [FW_W-1:0]   width_reg;
    logic [FH_W-1:0]   height_reg;
    logic [MASK_W-1:0] mask_reg;
    logic [PIX_W-1:0]  upper_row [MAX_W];
    logic [PIX_W-1:0]  lower_row [MAX_W];
    logic [PIX_W-1:0]  win [WIN_N];
    int unsigned       in_row, in_col, out_row, out_col;
    boundary_t         expected_q [$];
    int unsigned       errors;

    function new();
      width_reg = FW_RST;
      height_reg = FH_RST;
      mask_reg = MASK_RST;
      foreach (upper_row[k]) begin
        upper_row[k] = '0;
        lower_row[k] = '0;
      end
      errors = 0;
      start_frame();
    endfunction

    function void start_frame();
      in_row = 0;
      in_col = 0;
      out_row = 0;
      out_col = 0;
      foreach (win[k]) win[k] = PIX_MAX;
    endfunction

    function int unsigned cols_eff();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_W) return MAX_W;
      return width_reg;
    endfunction

    function int unsigned rows_eff();
      if (height_reg == 0) return 1;
      if (height_reg > MAX_H) return MAX_H;
      return height_reg;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void apply_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_FRAME_WIDTH: begin
          width_reg = data[FW_W-1:0];
          start_frame();
        end
        CFG_FRAME_HEIGHT: begin
          height_reg = data[FH_W-1:0];
          start_frame();
        end
        CFG_ELEMENT_MASK: begin
          mask_reg = data[MASK_W-1:0];
        end
        default: ;
      endcase
    endfunction

    function void take_request(logic func, logic [PIX_W-1:0] pix);
      int unsigned cols, rows, c, r, a, b, k;
      logic in_frame, emit, last;
      logic [PIX_W-1:0] p, up, lo, ero, res;
      logic [PIX_W-1:0] e [WIN_N];
      cols = cols_eff();
      rows = rows_eff();
      in_frame = (in_row < rows);
      // drop early flush
      if (in_frame && func == FUNC_FLUSH) return;
      p = in_frame ? pix : PIX_MAX;
      c = in_col;
      up = (in_row >= 2) ? upper_row[c] : PIX_MAX;
      lo = (in_row >= 1) ? lower_row[c] : PIX_MAX;
      emit = (in_row >= 2) || (in_row >= 1 && in_col >= 1);
      for (r = 0; r < 3; r++) begin
        if (in_col == 0) begin
          e[r*3]     = win[r*3+1];
          e[r*3+1]   = win[r*3+2];
          e[r*3+2]   = PIX_MAX;
          win[r*3]   = PIX_MAX;
          win[r*3+1] = PIX_MAX;
        end else begin
          win[r*3]   = win[r*3+1];
          win[r*3+1] = win[r*3+2];
        end
      end
      win[2] = up;
      win[5] = lo;
      win[8] = p;
      if (in_col != 0) begin
        for (k = 0; k < WIN_N; k++) e[k] = win[k];
      end
      if (in_frame) begin
        upper_row[c] = lower_row[c];
        lower_row[c] = p;
      end
      in_col++;
      if (in_col >= cols) begin
        in_col = 0;
        in_row++;
      end
      if (!emit) return;
      ero = PIX_MAX;
      for (a = 0; a < 3; a++) begin
        for (b = 0; b < 3; b++) begin
          if (mask_reg[a*3+b]) ero = ero & e[(2-a)*3 + (2-b)];
        end
      end
      res = e[4] - ero;
      last = (out_row == rows - 1) && (out_col == cols - 1);
      expected_q.push_back('{boundary_pixel: res, frame_last: last});
      out_col++;
      if (out_col >= cols) begin
        out_col = 0;
        out_row++;
      end
      if (last) start_frame();
    endfunction

    function void check_result(logic [PIX_W-1:0] bp, logic fl);
      boundary_t want;
      if (expected_q.size() == 0) begin
        $error("boundary result %0d (frame_last %0b) with none expected", bp, fl);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (bp !== want.boundary_pixel) begin
        $error("boundary_pixel: expected %0d, got %0d", want.boundary_pixel, bp);
        errors++;
      end
      if (fl !== want.frame_last) begin
        $error("frame_last: expected %0b, got %0b", want.frame_last, fl);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  bit                    no_idle;
  int unsigned           items_sent;
  int unsigned           quiet_cycles;

  mbe_in_if  in_chan();
  mbe_out_if out_chan();

  boundary_predictor pred = new();

  morph_boundary_extract_3x3_top #(.MAX_WIDTH(MAX_W)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) pred.apply_reg(cfg_reg_t'(cfg_index), cfg_wdata);
      if (in_chan.valid && in_chan.ready) pred.take_request(in_chan.func, in_chan.pixel_in);
      if (out_chan.valid && out_chan.ready) begin
        pred.check_result(out_chan.boundary_pixel, out_chan.frame_last);
      end
    end
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  initial begin
    int unsigned run_len, stall_len;
    out_chan.ready = 1'b0;
    @(negedge clk);
    forever begin
      out_chan.ready <= 1'b1;
      run_len = $urandom_range(1, 16);
      repeat (run_len) @(negedge clk);
      stall_len = pick_gap();
      if (stall_len != 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall_len) @(negedge clk);
      end
    end
  end

  function automatic logic [PIX_W-1:0] next_pixel(texture_t style);
    case (style)
      TEXTURE_NOISE:  return PIX_W'($urandom);
      TEXTURE_BINARY: return $urandom_range(0, 1) ? PIX_MAX : '0;
      default:        return PIX_MAX - PIX_W'($urandom_range(0, 3));
    endcase
  endfunction

  // leave valid high only when the next request follows at once
  task automatic send_item(input logic func, input logic [PIX_W-1:0] pix);
    int unsigned gap;
    in_chan.valid    <= 1'b1;
    in_chan.func     <= func;
    in_chan.pixel_in <= pix;
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
    gap = pick_gap();
    if (gap != 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic settle();
    in_chan.valid <= 1'b0;
    while (pred.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_geometry(input logic [CFG_DATA_W-1:0] wval,
                              input logic [CFG_DATA_W-1:0] hval);
    settle();
    write_reg(CFG_FRAME_WIDTH, wval);
    write_reg(CFG_FRAME_HEIGHT, hval);
  endtask

  task automatic run_frame(input int unsigned cols, input int unsigned rows,
                           input bit complete, input texture_t style);
    int unsigned total, cut, i;
    total = cols * rows;
    cut = complete ? total : $urandom_range(0, total - 1);
    for (i = 0; i < cut; i++) begin
      if ($urandom_range(0, 19) == 0) send_item(FUNC_FLUSH, PIX_W'($urandom));
      if ($urandom_range(0, 199) == 0) begin
        settle();
        write_reg(CFG_ELEMENT_MASK, CFG_DATA_W'($urandom));
      end
      send_item(FUNC_PIXEL, next_pixel(style));
      items_sent++;
    end
    if (complete) begin
      for (i = 0; i <= cols; i++) begin
        send_item($urandom_range(0, 1) ? FUNC_FLUSH : FUNC_PIXEL, PIX_W'($urandom));
        items_sent++;
      end
    end
  endtask

  initial begin
    int unsigned cols, rows, r, i;
    logic [CFG_DATA_W-1:0] wval, hval;
    logic [PIX_W-1:0] ramp [9];
    ramp = '{8'h00, 8'hFF, 8'h01, 8'hFE, 8'h80, 8'h7F, 8'h55, 8'hAA, 8'hFF};
    in_chan.valid    = 1'b0;
    in_chan.func     = FUNC_PIXEL;
    in_chan.pixel_in = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_FRAME_WIDTH;
    cfg_wdata = '0;
    no_idle    = 1'b0;
    items_sent = 0;
    rst_n      = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // 3x3 frame on the reset mask, early flush, mask change mid-frame, surplus pixel in the tail
    set_geometry(13'd3, 13'd3);
    for (i = 0; i < 9; i++) begin
      send_item(FUNC_PIXEL, ramp[i]);
      if (i == 4) send_item(FUNC_FLUSH, 8'h00);
      if (i == 6) begin
        settle();
        write_reg(CFG_ELEMENT_MASK, 13'h1FF);
      end
    end
    send_item(FUNC_FLUSH, 8'h5A);
    send_item(FUNC_PIXEL, 8'hC3);
    send_item(FUNC_FLUSH, 8'h00);
    send_item(FUNC_FLUSH, 8'hFF);

    // width 0 acts as 1, empty mask
    settle();
    write_reg(CFG_ELEMENT_MASK, 13'h000);
    set_geometry(13'd0, 13'd2);
    send_item(FUNC_PIXEL, 8'hFF);
    send_item(FUNC_PIXEL, 8'h00);
    send_item(FUNC_FLUSH, 8'h00);
    send_item(FUNC_FLUSH, 8'h00);

    // partial frame, aborted by the next geometry write
    settle();
    write_reg(CFG_ELEMENT_MASK, 13'h0BA);
    set_geometry(13'd2, 13'd2);
    send_item(FUNC_PIXEL, 8'h10);
    send_item(FUNC_PIXEL, 8'hF0);
    send_item(FUNC_PIXEL, 8'h0F);
    send_item(FUNC_PIXEL, 8'h33);

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 70) cols = $urandom_range(1, 8);
      else if (r < 93) cols = $urandom_range(9, 24);
      else cols = $urandom_range(25, 48);
      rows = $urandom_range(1, 6);
      wval = cols;
      hval = rows;
      if (cols == 1 && $urandom_range(0, 1) == 0) wval = '0;
      if (rows == 1 && $urandom_range(0, 1) == 0) hval = '0;
      if ($urandom_range(0, 4) == 0) wval[CFG_DATA_W-1:FW_W] = (CFG_DATA_W-FW_W)'($urandom);
      no_idle = ($urandom_range(0, 5) == 0);
      set_geometry(wval, hval);
      r = $urandom_range(0, 9);
      if (r == 0) write_reg(CFG_ELEMENT_MASK, 13'h000);
      else if (r == 1) write_reg(CFG_ELEMENT_MASK, 13'h1FF);
      else if (r < 8) write_reg(CFG_ELEMENT_MASK, CFG_DATA_W'($urandom));
      run_frame(cols, rows, $urandom_range(0, 7) != 0, texture_t'($urandom_range(0, 2)));
    end

    // widest rows with an out-of-range width, then an out-of-range height
    no_idle = 1'b0;
    set_geometry(13'd511, 13'd2);
    write_reg(CFG_ELEMENT_MASK, 13'd84);
    for (i = 0; i < MAX_W + WIDE_EXTRA; i++) begin
      send_item(FUNC_PIXEL, next_pixel(TEXTURE_NOISE));
    end
    set_geometry(13'd0, 13'd8191);
    for (i = 0; i < TALL_ITEMS; i++) begin
      send_item(FUNC_PIXEL, next_pixel(TEXTURE_BINARY));
    end

    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (pred.errors == 0 && pred.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
